[design/gsbl_pkg.sv]
`timescale 1ns / 1ps
package gsbl_pkg;

  localparam int MAX_ROWS  = 512;
  localparam int MAX_COLS  = 512;
  localparam int FRAC_BITS = 16;
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int CNT_W     = 10;
  localparam int DIV_W     = 32 + FRAC_BITS;
  localparam int PROD_W    = 33 + FRAC_BITS + 1;

  localparam logic [2:0] REG_ORIGIN_LAT = 3'd0;
  localparam logic [2:0] REG_ORIGIN_LON = 3'd1;
  localparam logic [2:0] REG_MAX_LAT    = 3'd2;
  localparam logic [2:0] REG_MAX_LON    = 3'd3;
  localparam logic [2:0] REG_STEP_LAT   = 3'd4;
  localparam logic [2:0] REG_STEP_LON   = 3'd5;
  localparam logic [2:0] REG_NUM_ROWS   = 3'd6;
  localparam logic [2:0] REG_NUM_COLS   = 3'd7;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic               op;
    logic signed [31:0] query_lat;
    logic signed [31:0] query_lon;
    logic [8:0]         load_row;
    logic [8:0]         load_col;
    logic signed [31:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] shift;
    logic               inside_res;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] origin_lat;
    logic signed [31:0] origin_lon;
    logic signed [31:0] max_lat;
    logic signed [31:0] max_lon;
    logic [30:0]        step_lat;
    logic [30:0]        step_lon;
    logic [CNT_W-1:0]   num_rows;
    logic [CNT_W-1:0]   num_cols;
  } cfg_t;

  typedef enum logic [1:0] {
    JOB_LOAD,
    JOB_QUERY,
    JOB_OUTSIDE
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic signed [31:0] value;
    logic [31:0]        d_lat;
    logic [31:0]        d_lon;
  } job_t;

  function automatic logic signed [31:0] lerp_round(input logic signed [31:0] a,
                                                    input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] b;
    logic signed [PROD_W-1:0] s;
    b = p + (PROD_W'(1) <<< (FRAC_BITS - 1));
    s = (b >>> FRAC_BITS) + PROD_W'(a);
    return s[31:0];
  endfunction

endpackage

[design/gsbl_front.sv]
`timescale 1ns / 1ps
module gsbl_front (
  input  logic               clk,
  input  logic               rst,
  input  gsbl_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  gsbl_pkg::in_item_t in_item,
  output logic               push,
  input  logic               push_ready,
  output gsbl_pkg::job_t     push_job
);

  logic              fvalid;
  gsbl_pkg::job_t    job;
  gsbl_pkg::job_t    job_next;
  logic              accept;
  logic              outside;
  logic signed [32:0] d_lat;
  logic signed [32:0] d_lon;

  assign in_stall = fvalid && !push_ready;
  assign accept   = in_valid && !in_stall;
  assign push     = fvalid;
  assign push_job = job;

  always_comb begin
    outside = (in_item.query_lat < cfg.origin_lat) || (in_item.query_lat > cfg.max_lat) ||
              (in_item.query_lon < cfg.origin_lon) || (in_item.query_lon > cfg.max_lon);
    d_lat = 33'(in_item.query_lat) - 33'(cfg.origin_lat);
    d_lon = 33'(in_item.query_lon) - 33'(cfg.origin_lon);
    job_next.row   = in_item.load_row[gsbl_pkg::ROW_W-1:0];
    job_next.col   = in_item.load_col[gsbl_pkg::COL_W-1:0];
    job_next.value = in_item.load_value;
    job_next.d_lat = d_lat[31:0];
    job_next.d_lon = d_lon[31:0];
    if (in_item.op == gsbl_pkg::OP_LOAD) begin
      job_next.kind = gsbl_pkg::JOB_LOAD;
    end else if (outside) begin
      job_next.kind = gsbl_pkg::JOB_OUTSIDE;
    end else begin
      job_next.kind = gsbl_pkg::JOB_QUERY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
    end else if (accept) begin
      fvalid <= 1'b1;
    end else if (push_ready) begin
      fvalid <= 1'b0;
    end
    if (accept) begin
      job <= job_next;
    end
  end

endmodule

[design/gsbl_queue.sv]
`timescale 1ns / 1ps
module gsbl_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           push_ready,
  input  gsbl_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop,
  output gsbl_pkg::job_t pop_job
);

  gsbl_pkg::job_t entry [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_job    = entry[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
    if (do_push) begin
      entry[wr_ptr] <= push_job;
    end
  end

endmodule

[design/gsbl_back.sv]
`timescale 1ns / 1ps
module gsbl_back (
  input  logic                clk,
  input  logic                rst,
  input  gsbl_pkg::cfg_t      cfg,
  input  logic                pop_valid,
  output logic                pop,
  input  gsbl_pkg::job_t      pop_job,
  output logic                out_valid,
  input  logic                out_stall,
  output gsbl_pkg::out_item_t out_item
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_IDX, S_RD00, S_RD01, S_RD10, S_RD11, S_CAP,
    S_MTOP, S_MBOT, S_MRES, S_MFIN, S_DONE
  } state_t;

  localparam int AW = gsbl_pkg::ROW_W + gsbl_pkg::COL_W;
  localparam int DW = gsbl_pkg::DIV_W;
  localparam int PW = gsbl_pkg::PROD_W;
  localparam int FB = gsbl_pkg::FRAC_BITS;

  state_t state;

  logic signed [31:0] mem [2**AW];
  logic signed [31:0] rdata;
  logic [AW-1:0]      addr;
  logic               we;

  logic [DW-1:0]      nd_lat, nd_lon, q_lat, q_lon;
  logic [31:0]        rem_lat, rem_lon;
  logic [5:0]         cnt;
  logic [30:0]        s_lat, s_lon;
  logic [32:0]        t_lat, t_lon;
  logic [31:0]        r_lat_next, r_lon_next;
  logic               b_lat, b_lon;

  logic [gsbl_pkg::CNT_W-1:0] rows, cols;
  logic [gsbl_pkg::ROW_W-1:0] r0, r1, r0_c;
  logic [gsbl_pkg::COL_W-1:0] c0, c1, c0_c;
  logic [FB-1:0]              f_lat, f_lon;

  logic signed [31:0] v00, v01, v10, v11, top, bottom;
  logic signed [PW-1:0] prod;
  logic can_out;
  logic out_load;

  assign can_out = !out_valid || !out_stall;

  always_comb begin
    s_lat = (cfg.step_lat == '0) ? 31'd1 : cfg.step_lat;
    s_lon = (cfg.step_lon == '0) ? 31'd1 : cfg.step_lon;
    if (cfg.num_rows == '0) begin
      rows = 10'd1;
    end else if (cfg.num_rows > 10'(gsbl_pkg::MAX_ROWS)) begin
      rows = 10'(gsbl_pkg::MAX_ROWS);
    end else begin
      rows = cfg.num_rows;
    end
    if (cfg.num_cols == '0) begin
      cols = 10'd1;
    end else if (cfg.num_cols > 10'(gsbl_pkg::MAX_COLS)) begin
      cols = 10'(gsbl_pkg::MAX_COLS);
    end else begin
      cols = cfg.num_cols;
    end

    t_lat = {rem_lat, nd_lat[DW-1]} - {2'b0, s_lat};
    t_lon = {rem_lon, nd_lon[DW-1]} - {2'b0, s_lon};
    b_lat = !t_lat[32];
    b_lon = !t_lon[32];
    r_lat_next = b_lat ? t_lat[31:0] : {rem_lat[30:0], nd_lat[DW-1]};
    r_lon_next = b_lon ? t_lon[31:0] : {rem_lon[30:0], nd_lon[DW-1]};

    if (q_lat[DW-1:FB] > 32'(rows - 10'd1)) begin
      r0_c = gsbl_pkg::ROW_W'(rows - 10'd1);
    end else begin
      r0_c = q_lat[FB+gsbl_pkg::ROW_W-1:FB];
    end
    if (q_lon[DW-1:FB] > 32'(cols - 10'd1)) begin
      c0_c = gsbl_pkg::COL_W'(cols - 10'd1);
    end else begin
      c0_c = q_lon[FB+gsbl_pkg::COL_W-1:FB];
    end

    pop = 1'b0;
    if (state == S_IDLE && pop_valid) begin
      pop = (pop_job.kind != gsbl_pkg::JOB_OUTSIDE) || can_out;
    end
    we = pop && (pop_job.kind == gsbl_pkg::JOB_LOAD);
    out_load = (pop && (pop_job.kind == gsbl_pkg::JOB_OUTSIDE)) ||
               ((state == S_DONE) && can_out);

    unique case (state)
      S_RD00:  addr = {r0, c0};
      S_RD01:  addr = {r0, c1};
      S_RD10:  addr = {r1, c0};
      S_RD11:  addr = {r1, c1};
      default: addr = {pop_job.row, pop_job.col};
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= pop_job.value;
    end
    rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            unique case (pop_job.kind)
              gsbl_pkg::JOB_OUTSIDE: begin
                out_item.shift      <= '0;
                out_item.inside_res <= 1'b0;
              end
              gsbl_pkg::JOB_QUERY: begin
                nd_lat  <= {pop_job.d_lat, FB'(0)};
                nd_lon  <= {pop_job.d_lon, FB'(0)};
                rem_lat <= '0;
                rem_lon <= '0;
                cnt     <= 6'(DW - 1);
                state   <= S_DIV;
              end
              default: begin
              end
            endcase
          end
        end
        S_DIV: begin
          nd_lat  <= nd_lat << 1;
          nd_lon  <= nd_lon << 1;
          rem_lat <= r_lat_next;
          rem_lon <= r_lon_next;
          q_lat   <= {q_lat[DW-2:0], b_lat};
          q_lon   <= {q_lon[DW-2:0], b_lon};
          cnt     <= cnt - 6'd1;
          if (cnt == '0) begin
            state <= S_IDX;
          end
        end
        S_IDX: begin
          r0    <= r0_c;
          c0    <= c0_c;
          r1    <= (10'(r0_c) + 10'd1 >= rows) ? r0_c : r0_c + 1'b1;
          c1    <= (10'(c0_c) + 10'd1 >= cols) ? c0_c : c0_c + 1'b1;
          f_lat <= q_lat[FB-1:0];
          f_lon <= q_lon[FB-1:0];
          state <= S_RD00;
        end
        S_RD00: state <= S_RD01;
        S_RD01: begin
          v00   <= rdata;
          state <= S_RD10;
        end
        S_RD10: begin
          v01   <= rdata;
          state <= S_RD11;
        end
        S_RD11: begin
          v10   <= rdata;
          state <= S_CAP;
        end
        S_CAP: begin
          v11   <= rdata;
          state <= S_MTOP;
        end
        S_MTOP: begin
          prod  <= PW'((33'(v01) - 33'(v00)) * $signed({1'b0, f_lon}));
          state <= S_MBOT;
        end
        S_MBOT: begin
          top   <= gsbl_pkg::lerp_round(v00, prod);
          prod  <= PW'((33'(v11) - 33'(v10)) * $signed({1'b0, f_lon}));
          state <= S_MRES;
        end
        S_MRES: begin
          bottom <= gsbl_pkg::lerp_round(v10, prod);
          state  <= S_MFIN;
        end
        S_MFIN: begin
          prod  <= PW'((33'(bottom) - 33'(top)) * $signed({1'b0, f_lat}));
          state <= S_DONE;
        end
        S_DONE: begin
          if (can_out) begin
            out_item.shift      <= gsbl_pkg::lerp_round(top, prod);
            out_item.inside_res <= 1'b1;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[design/grid_shift_bilinear_lookup.sv]
`timescale 1ns / 1ps
// Shift grid lookup. Each request on the input channel either loads one grid word
// (op clear) or queries a point (op set). A load gives no result; a query gives one
// result request on the output channel carrying the interpolated shift and an
// inside flag, which is clear with a zero shift when the point lies outside the
// bounding rectangle. Both channels use valid and stall.
// The front stage checks the bounds and registers the offsets, and a two
// entry queue separates it from the back end. Loads retire at one per cycle while
// the back end is idle. A query inside the rectangle holds the back end while it is
// taken, run through a one-bit-per-cycle divider that splits both offsets into cell
// index and fraction, turned into indexes, its four corners read through the single
// memory port, the last corner captured, and then multiplied and rounded. An outside
// query retires from the idle state once the output can take it, with no divider or
// memory reads; its result goes straight into the output register.
// Reset clears the control state and sets the registers to their defaults; the
// grid memory is not cleared and must be loaded before it is read. When the
// receiver stalls, the result is held and the back end waits before giving another
// result, while the queue and front stage go on accepting until full.
module grid_shift_bilinear_lookup (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  gsbl_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output gsbl_pkg::out_item_t out_item
);

  gsbl_pkg::cfg_t cfg;
  gsbl_pkg::job_t push_job;
  gsbl_pkg::job_t pop_job;
  logic           push, push_ready, pop, pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_lat <= '0;
      cfg.origin_lon <= '0;
      cfg.max_lat    <= '0;
      cfg.max_lon    <= '0;
      cfg.step_lat   <= 31'd1;
      cfg.step_lon   <= 31'd1;
      cfg.num_rows   <= 10'd1;
      cfg.num_cols   <= 10'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gsbl_pkg::REG_ORIGIN_LAT: cfg.origin_lat <= cfg_data;
        gsbl_pkg::REG_ORIGIN_LON: cfg.origin_lon <= cfg_data;
        gsbl_pkg::REG_MAX_LAT:    cfg.max_lat    <= cfg_data;
        gsbl_pkg::REG_MAX_LON:    cfg.max_lon    <= cfg_data;
        gsbl_pkg::REG_STEP_LAT:   cfg.step_lat   <= cfg_data[30:0];
        gsbl_pkg::REG_STEP_LON:   cfg.step_lon   <= cfg_data[30:0];
        gsbl_pkg::REG_NUM_ROWS:   cfg.num_rows   <= cfg_data[9:0];
        gsbl_pkg::REG_NUM_COLS:   cfg.num_cols   <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  gsbl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .push       (push),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  gsbl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_job    (pop_job)
  );

  gsbl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_job   (pop_job),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
